@@ rtl/core/fsc_pkg.sv @@
// Shared types, constants and state codes of the frustum sphere classifier.
`default_nettype none
package fsc_pkg;

  localparam int FracBits   = 16;
  localparam int PlaneCount = 6;

  typedef enum logic [1:0] {
    REL_DISJOINT   = 2'd0,
    REL_INTERSECTS = 2'd1,
    REL_CONTAINED  = 2'd2
  } rel_t;

  typedef struct packed {
    logic               req_type;
    logic [1:0]         row_index;
    logic signed [31:0] elem_col0;
    logic signed [31:0] elem_col1;
    logic signed [31:0] elem_col2;
    logic signed [31:0] elem_col3;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0]        sphere_radius;
  } in_word_t;

  typedef struct packed {
    logic [1:0] relation;
    logic       visible;
  } out_word_t;

  // Top-level sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MWR,     // write the four columns of a loaded row
    ST_MLOAD,   // fetch matrix column pair for one row of a plane
    ST_MCAP,    // capture raw component
    ST_NORM,    // find exponent k
    ST_SQ,      // accumulate squares
    ST_SQRT,    // iterate square root
    ST_DIV,     // iterate scaled division of one component
    ST_PWR,     // write plane component
    ST_SRD,     // read plane component for sphere test
    ST_SMAC,    // accumulate one product
    ST_SCMP,    // compare one plane distance
    ST_SOUT     // emit result
  } fsc_state_t;

  localparam logic [1:0] PlaneCol [PlaneCount] = '{2'd2, 2'd2, 2'd0, 2'd0, 2'd1, 2'd1};
  localparam logic       PlaneNeg [PlaneCount] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
  localparam logic       PlaneUse3[PlaneCount] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};

endpackage
`default_nettype wire

@@ rtl/core/fsc_ram.sv @@
// Synchronous RAM with one write port and one registered read port.
`default_nettype none
module fsc_ram #(
  parameter int Depth = 16,
  parameter int Width = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output      logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write and read the array.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/core/frustum_sphere_classifier_unit.sv @@
// Top level: matrix and plane memories, plane derivation and sphere test sequencer.
`default_nettype none
// Words are handled one at a time while busy is high. A matrix-row load
// writes its four elements into the matrix memory one by one after
// acceptance. A load of row 3 then derives the six normalized planes one
// after another: per plane the matrix reads, exponent and squares, a
// 32-step square root, and for each of the four components a long
// division of 34 plus the fraction shift steps (up to 50 for a normal, up to
// 80 for the offset) with setup and write. A zero-length normal skips the
// square root and division. A sphere test walks the six stored planes
// through one shared multiply-accumulate, 4 plane memory reads and one
// compare per plane, set by the one plane memory port; the test ends
// early when a plane lies beyond the radius. The result is presented on
// out_strobe for one cycle; the receiver cannot stall it. Both memories
// power up undefined and are swept to zero after reset while busy is
// high.
module frustum_sphere_classifier_unit
  import fsc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output      logic      busy,
  input  wire in_word_t  in_word,
  output      logic      out_strobe,
  output      out_word_t out_word
);
  fsc_state_t state_r, state_nxt;

  logic        clr_r;
  logic [4:0]  clr_cnt_r;

  in_word_t    req_r;

  logic        m_we;
  logic [3:0]  m_waddr, m_raddr;
  logic [31:0] m_wdata, m_rdata;

  logic        p_we;
  logic [4:0]  p_waddr, p_raddr;
  logic [31:0] p_wdata, p_rdata;

  // derivation registers
  logic [2:0]  pl_r;
  logic [1:0]  row_r;
  logic        half_r;
  logic signed [31:0] mcol_r;
  logic signed [33:0] raw_r [4];
  logic [63:0] sum_r;
  logic [63:0] sqx_r, sqres_r;
  logic [5:0]  sqi_r;
  logic [31:0] len_r;
  logic [31:0] dq_r, dr_r;
  logic [33:0] dn_r;
  logic [6:0]  dcnt_r;
  logic        dsat_r;

  // sphere registers
  logic signed [65:0] acc_r;
  logic [2:0]  inside_r;

  // Shared helpers
  logic [2:0]  pl_idx;
  logic [33:0] mag [4];
  logic [5:0]  msb;
  logic [33:0] mmax;
  logic signed [6:0] k_s;
  logic [63:0] scl [3];
  logic [5:0]  shift_tot;
  logic [63:0] sq_trial;
  logic [63:0] sq_prod;
  logic [33:0] d_trial;
  logic        rnd;
  logic [32:0] q_rnd;
  logic signed [33:0] m_ext, c_ext;
  logic signed [65:0] rad_ext;
  logic signed [31:0] mac_op;
  logic signed [63:0] mac_prod;
  logic [33:0] dnum;

  fsc_ram #(.Depth(16), .Width(32)) u_mat (
    .clk, .we(m_we), .waddr(m_waddr), .wdata(m_wdata), .raddr(m_raddr), .rdata(m_rdata)
  );
  fsc_ram #(.Depth(24), .Width(32)) u_pln (
    .clk, .we(p_we), .waddr(p_waddr), .wdata(p_wdata), .raddr(p_raddr), .rdata(p_rdata)
  );

  assign pl_idx = pl_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag[i] = raw_r[i][33] ? 34'(-raw_r[i]) : 34'(raw_r[i]);
    end
    mmax = mag[0];
    if (mag[1] > mmax) mmax = mag[1];
    if (mag[2] > mmax) mmax = mag[2];
    msb = '0;
    for (int b = 0; b < 34; b++) begin
      if (mmax[b]) msb = 6'(b);
    end
    k_s = 7'(30) - 7'(msb);
    for (int i = 0; i < 3; i++) begin
      scl[i] = k_s[6] ? (64'(mag[i]) >> 7'(-k_s)) : (64'(mag[i]) << k_s);
    end
  end

  // Sign-extend matrix words into the raw adder
  assign m_ext = 34'(signed'(m_rdata));
  assign c_ext = 34'(mcol_r);
  assign rad_ext = 66'(req_r.sphere_radius) << FracBits;

  // Division numerator: scaled magnitude or d magnitude
  always_comb begin
    dnum = (row_r == 2'd3) ? mag[3] : scl[row_r][33:0];
    shift_tot = (row_r == 2'd3) ? 6'(7'(FracBits) + k_s) : 6'(FracBits);
  end

  assign sq_trial = sqres_r + (64'd1 << {sqi_r, 1'b0});
  assign sq_prod  = scl[row_r][31:0] * scl[row_r][31:0];
  assign d_trial  = {1'b0, dr_r, dn_r[33]} - {2'b00, len_r};
  assign rnd      = ({dr_r, 1'b0} >= {1'b0, len_r});
  assign q_rnd    = {1'b0, dq_r} + 33'(rnd);

  // Sphere product operand: centre coordinate or one for the offset
  assign mac_op = (row_r == 2'd0) ? req_r.center_x :
                  (row_r == 2'd1) ? req_r.center_y :
                  (row_r == 2'd2) ? req_r.center_z : 32'(1 << FracBits);
  assign mac_prod = signed'(p_rdata) * mac_op;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start && !busy) begin
          if (in_word.req_type) state_nxt = ST_SRD;
          else state_nxt = ST_MWR;
        end
      end
      ST_MWR: begin
        if (row_r == 2'd3) state_nxt = (req_r.row_index == 2'd3) ? ST_MLOAD : ST_IDLE;
      end
      ST_MLOAD: state_nxt = ST_MCAP;
      ST_MCAP:  state_nxt = (row_r == 2'd3 && (half_r || !PlaneUse3[pl_idx])) ?
                            ST_NORM : ST_MLOAD;
      ST_NORM:  state_nxt = (mmax == '0) ? ST_PWR : ST_SQ;
      ST_SQ:    state_nxt = (row_r == 2'd2) ? ST_SQRT : ST_SQ;
      ST_SQRT:  state_nxt = (sqi_r == '0) ? ST_DIV : ST_SQRT;
      ST_DIV:   state_nxt = (!half_r && (dcnt_r == '0 || dsat_r)) ? ST_PWR : ST_DIV;
      ST_PWR: begin
        if (row_r != 2'd3) state_nxt = (mmax == '0) ? ST_PWR : ST_DIV;
        else if (pl_r == 3'(PlaneCount - 1)) state_nxt = ST_IDLE;
        else state_nxt = ST_MLOAD;
      end
      ST_SRD:  state_nxt = ST_SMAC;
      ST_SMAC: state_nxt = (row_r == 2'd3) ? ST_SCMP : ST_SRD;
      ST_SCMP: begin
        if (acc_r > rad_ext || pl_r == 3'(PlaneCount - 1)) state_nxt = ST_SOUT;
        else state_nxt = ST_SRD;
      end
      ST_SOUT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and memory controls
  always_comb begin
    busy     = clr_r || (state_r != ST_IDLE);
    m_we     = 1'b0;
    m_waddr  = {req_r.row_index, row_r};
    m_wdata  = '0;
    m_raddr  = '0;
    p_we     = 1'b0;
    p_waddr  = {pl_r, row_r};
    p_wdata  = '0;
    p_raddr  = {pl_r, row_r};
    if (clr_r) begin
      m_we = 1'b1; m_waddr = clr_cnt_r[3:0];
      p_we = 1'b1; p_waddr = clr_cnt_r;
    end
    unique case (state_r)
      ST_MWR: begin
        m_we    = 1'b1;
        m_wdata = (row_r == 2'd0) ? req_r.elem_col0 :
                  (row_r == 2'd1) ? req_r.elem_col1 :
                  (row_r == 2'd2) ? req_r.elem_col2 : req_r.elem_col3;
      end
      ST_MLOAD: m_raddr = {row_r, half_r ? 2'd3 : PlaneCol[pl_idx]};
      ST_PWR: begin
        p_we = 1'b1;
        if (mmax == '0) p_wdata = '0;
        else begin
          p_wdata = (dsat_r || q_rnd > 33'h7FFF_FFFF) ? 32'h7FFF_FFFF : q_rnd[31:0];
          if (raw_r[row_r][33]) p_wdata = 32'(-p_wdata);
        end
      end
      default: ;
    endcase
    out_strobe = (state_r == ST_SOUT);
    out_word.relation = (inside_r == 3'(PlaneCount)) ? REL_CONTAINED :
                        (acc_r > rad_ext) ? REL_DISJOINT : REL_INTERSECTS;
    out_word.visible  = (out_word.relation != REL_DISJOINT);
  end

  // State register and clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + 5'd1;
        if (clr_cnt_r == 5'd23) clr_r <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (start && !busy) begin
          req_r  <= in_word;
          pl_r   <= '0;
          row_r  <= '0;
          half_r <= 1'b0;
          acc_r  <= '0;
          inside_r <= '0;
        end
      end
      ST_MWR: row_r <= row_r + 2'd1;
      ST_MLOAD: ;
      ST_MCAP: begin
        if (!half_r) begin
          mcol_r <= signed'(m_rdata);
          if (PlaneUse3[pl_idx]) half_r <= 1'b1;
          else begin
            raw_r[row_r] <= PlaneNeg[pl_idx] ? -m_ext : m_ext;
            row_r <= row_r + 2'd1;
          end
        end else begin
          raw_r[row_r] <= (PlaneNeg[pl_idx] ? -c_ext : c_ext) - m_ext;
          half_r <= 1'b0;
          row_r  <= row_r + 2'd1;
        end
        if (row_r == 2'd3 && (half_r || !PlaneUse3[pl_idx])) row_r <= 2'd0;
      end
      ST_NORM: begin
        sum_r <= '0;
        row_r <= '0;
      end
      ST_SQ: begin
        sum_r <= sum_r + sq_prod;
        row_r <= row_r + 2'd1;
        if (row_r == 2'd2) begin
          sqx_r <= sum_r + sq_prod;
          sqres_r <= '0;
          sqi_r <= 6'd31;
          row_r <= '0;
        end
      end
      ST_SQRT: begin
        if (sqx_r >= sq_trial) begin
          sqx_r   <= sqx_r - sq_trial;
          sqres_r <= (sqres_r >> 1) + (64'd1 << {sqi_r, 1'b0});
        end else sqres_r <= sqres_r >> 1;
        sqi_r <= sqi_r - 6'd1;
        if (sqi_r == '0) begin
          len_r  <= (sqx_r >= sq_trial) ? 32'((sqres_r >> 1) + 64'd1) : 32'(sqres_r >> 1);
          dq_r   <= '0;
          dr_r   <= '0;
          dcnt_r <= '0;
          dsat_r <= 1'b0;
          half_r <= 1'b1;
        end
      end
      ST_DIV: begin
        // Long division of the numerator followed by the fraction shift zeros
        if (half_r) begin
          dq_r   <= '0;
          dr_r   <= '0;
          dn_r   <= dnum;
          dcnt_r <= 7'(shift_tot) + 7'd34;
          dsat_r <= 1'b0;
          half_r <= 1'b0;
        end else if (dcnt_r != '0 && !dsat_r) begin
          if (dq_r[30]) dsat_r <= 1'b1;
          else begin
            dq_r   <= {dq_r[30:0], !d_trial[33]};
            dr_r   <= d_trial[33] ? {dr_r[30:0], dn_r[33]} : d_trial[31:0];
            dn_r   <= {dn_r[32:0], 1'b0};
            dcnt_r <= dcnt_r - 7'd1;
          end
        end
      end
      ST_PWR: begin
        half_r <= 1'b1;
        if (row_r == 2'd3) begin
          row_r  <= '0;
          half_r <= 1'b0;
          pl_r   <= pl_r + 3'd1;
        end else row_r <= row_r + 2'd1;
      end
      ST_SRD: ;
      ST_SMAC: begin
        acc_r <= acc_r + 66'(mac_prod);
        row_r <= row_r + 2'd1;
      end
      ST_SCMP: begin
        if (acc_r < -rad_ext) inside_r <= inside_r + 3'd1;
        if (!(acc_r > rad_ext) && pl_r != 3'(PlaneCount - 1)) begin
          acc_r <= '0;
          pl_r  <= pl_r + 3'd1;
        end
      end
      ST_SOUT: ;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
// Self-checking testbench for the frustum sphere classifier: matrix loads and sphere tests.
`default_nettype none
module tb_top
  import fsc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SPHERE = 1'b1;
  localparam int   ONE_Q      = 32'h0001_0000;
  localparam int   STALL_LIMIT = 20000;
  localparam int   DRAIN_CYCLES = 60;

  // Expected classification of each accepted sphere word, oldest first.
  class cull_scoreboard;
    longint    mat[16];
    longint    pln[24];
    out_word_t expected_q[$];
    int        errors;

    function new();
      foreach (mat[i]) mat[i] = 0;
      foreach (pln[i]) pln[i] = 0;
      errors = 0;
    endfunction

    function automatic bit [63:0] int_sqrt(bit [63:0] x);
      bit [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= res + b) begin
          x = x - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    // Round n * 2^s / den half away from zero, saturate to 2^31-1.
    function automatic bit [63:0] round_div(bit [63:0] n, int s, bit [63:0] den);
      bit [63:0] q, r;
      q = n / den;
      r = n % den;
      for (int i = 0; i < s; i++) begin
        if (q >= 64'h1_0000_0000) return 64'h7FFF_FFFF;
        q = q << 1;
        r = r << 1;
        if (r >= den) begin
          r = r - den;
          q = q + 1;
        end
      end
      if (2 * r >= den) q = q + 1;
      return (q > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : q;
    endfunction

    // Extract and normalize the six outward planes from the stored matrix.
    function automatic void build_planes();
      int        col[6]  = '{2, 2, 0, 0, 1, 1};
      bit        neg[6]  = '{1, 0, 1, 0, 0, 1};
      bit        use3[6] = '{0, 1, 1, 1, 1, 1};
      longint    raw[4];
      bit [63:0] mag[4];
      bit [63:0] m, sum, len, q;
      int        k, s;
      for (int p = 0; p < 6; p++) begin
        m = 0;
        sum = 0;
        k = 0;
        for (int r = 0; r < 4; r++) begin
          raw[r] = neg[p] ? -mat[r*4 + col[p]] : mat[r*4 + col[p]];
          if (use3[p]) raw[r] = raw[r] - mat[r*4 + 3];
          mag[r] = (raw[r] < 0) ? -raw[r] : raw[r];
          if (r < 3 && mag[r] > m) m = mag[r];
        end
        if (m == 0) begin
          for (int r = 0; r < 4; r++) pln[p*4 + r] = 0;
          continue;
        end
        while (m >= 64'h8000_0000) begin
          m = m >> 1;
          k--;
        end
        while (m < 64'h4000_0000) begin
          m = m << 1;
          k++;
        end
        for (int r = 0; r < 3; r++) begin
          mag[r] = (k >= 0) ? (mag[r] << k) : (mag[r] >> (-k));
          sum = sum + mag[r] * mag[r];
        end
        len = int_sqrt(sum);
        for (int r = 0; r < 4; r++) begin
          s = (r < 3) ? FracBits : FracBits + k;
          q = round_div(mag[r], s, len);
          pln[p*4 + r] = (raw[r] < 0) ? -longint'(q) : longint'(q);
        end
      end
    endfunction

    // Apply an accepted word; queue the classification of a sphere.
    function automatic void note_word(in_word_t w);
      longint    cx, cy, cz, rad, plane_dist;
      int        inner;
      out_word_t e;
      rel_t      rel;
      if (w.req_type == REQ_LOAD) begin
        mat[w.row_index*4 + 0] = longint'(w.elem_col0);
        mat[w.row_index*4 + 1] = longint'(w.elem_col1);
        mat[w.row_index*4 + 2] = longint'(w.elem_col2);
        mat[w.row_index*4 + 3] = longint'(w.elem_col3);
        if (w.row_index == 2'd3) build_planes();
        return;
      end
      cx = longint'(w.center_x);
      cy = longint'(w.center_y);
      cz = longint'(w.center_z);
      rad = longint'({33'd0, w.sphere_radius}) << FracBits;
      rel = REL_INTERSECTS;
      inner = 0;
      for (int p = 0; p < 6; p++) begin
        plane_dist = pln[p*4] * cx + pln[p*4 + 1] * cy + pln[p*4 + 2] * cz
                   + (pln[p*4 + 3] << FracBits);
        if (plane_dist > rad) begin
          rel = REL_DISJOINT;
          break;
        end
        if (plane_dist < -rad) inner++;
      end
      if (rel != REL_DISJOINT && inner == 6) rel = REL_CONTAINED;
      e.relation = rel;
      e.visible = (rel != REL_DISJOINT);
      expected_q.push_back(e);
    endfunction

    function automatic void check_word(out_word_t got);
      out_word_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $realtime, got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.relation !== e.relation) begin
        $display("%0t: relation mismatch, expected %0d, actual %0d",
                 $realtime, e.relation, got.relation);
        errors++;
      end
      if (got.visible !== e.visible) begin
        $display("%0t: visible mismatch, expected %0d, actual %0d",
                 $realtime, e.visible, got.visible);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_word = '0;
  logic      out_strobe;
  out_word_t out_word;

  cull_scoreboard sb = new();
  int idle_pct = 19;
  int stall_count = 0;

  frustum_sphere_classifier_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_strobe(out_strobe),
    .out_word  (out_word)
  );

  always #5 clk = ~clk;

  // Check every strobed result word.
  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_word(out_word);
  end

  // Abort when nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  function automatic in_word_t rand_word();
    logic [287:0] noise;
    in_word_t     w;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom};
    w = noise[$bits(in_word_t)-1:0];
    return w;
  endfunction

  function automatic in_word_t load_word(logic [1:0] row, int c0, int c1, int c2, int c3);
    in_word_t w;
    w = rand_word();
    w.req_type = REQ_LOAD;
    w.row_index = row;
    w.elem_col0 = c0;
    w.elem_col1 = c1;
    w.elem_col2 = c2;
    w.elem_col3 = c3;
    return w;
  endfunction

  function automatic in_word_t sphere_word(int x, int y, int z, int r);
    in_word_t w;
    w = rand_word();
    w.req_type = REQ_SPHERE;
    w.center_x = x;
    w.center_y = y;
    w.center_z = z;
    w.sphere_radius = 31'(r);
    return w;
  endfunction

  // Present one word, optionally after a gap, and hold it until accepted.
  task automatic send_word(in_word_t w);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    sb.note_word(w);
  endtask

  function automatic int rand_elem();
    case ($urandom_range(9))
      0:       return $urandom;
      1:       return 0;
      default: return $signed($urandom_range(8 * ONE_Q)) - 4 * ONE_Q;
    endcase
  endfunction

  function automatic int rand_coord();
    if ($urandom_range(9) == 0) return $urandom;
    return $signed($urandom_range(4 * ONE_Q)) - 2 * ONE_Q;
  endfunction

  function automatic int rand_radius();
    case ($urandom_range(9))
      0:       return $urandom;
      1:       return 0;
      default: return $urandom_range(ONE_Q);
    endcase
  endfunction

  // Load a near-identity or random matrix, mostly rows in order.
  task automatic send_frame();
    bit ortho;
    int e[4];
    ortho = ($urandom_range(1) == 0);
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        e[c] = ortho ? ((r == c) ? ONE_Q : 0) + $signed($urandom_range(ONE_Q / 4)) - ONE_Q / 8
                     : rand_elem();
      end
      send_word(load_word(($urandom_range(9) == 0) ? 2'($urandom) : 2'(r),
                          e[0], e[1], e[2], e[3]));
    end
  endtask

  initial begin
    int sent;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sphere before any load sees all-zero planes.
    send_word(sphere_word(0, 0, 0, 0));
    send_word(sphere_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    // Identity matrix: unit box with z in [0,1].
    send_word(load_word(2'd0, ONE_Q, 0, 0, 0));
    send_word(load_word(2'd1, 0, ONE_Q, 0, 0));
    send_word(load_word(2'd2, 0, 0, ONE_Q, 0));
    send_word(load_word(2'd3, 0, 0, 0, ONE_Q));
    send_word(sphere_word(0, 0, ONE_Q / 2, ONE_Q / 10));
    send_word(sphere_word(3 * ONE_Q, 0, ONE_Q / 2, ONE_Q / 10));
    send_word(sphere_word(0, 0, ONE_Q, ONE_Q / 4));
    send_word(sphere_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    send_word(sphere_word(0, 0, ONE_Q / 2, 0));
    // Zero columns give zero-length normals.
    send_word(load_word(2'd0, 0, 0, 0, 0));
    send_word(load_word(2'd1, 0, 0, 0, 0));
    send_word(load_word(2'd2, 0, 0, 0, 0));
    send_word(load_word(2'd3, 0, 0, 0, 0));
    send_word(sphere_word(ONE_Q, ONE_Q, ONE_Q, 0));
    // Extreme elements, rows out of order.
    send_word(load_word(2'd3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    send_word(load_word(2'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    send_word(load_word(2'd0, 32'hFFFF_FFFF, 32'h8000_0000, 1, 32'h7FFF_FFFF));
    send_word(load_word(2'd2, 32'h7FFF_FFFF, 1, 32'h8000_0000, 32'hFFFF_FFFF));
    send_word(load_word(2'd3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
    send_word(sphere_word(ONE_Q, -ONE_Q, ONE_Q, ONE_Q));
    send_word(sphere_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));

    // Random frames, three idle profiles on the sender.
    sent = 0;
    while (sent < 1350) begin
      idle_pct = (sent < 450) ? 19 : (sent < 900) ? 58 : 0;
      if ($urandom_range(7) != 0) begin
        send_frame();
        sent += 4;
      end else begin
        send_word(rand_word());
        sent++;
      end
      repeat ($urandom_range(1, 10)) begin
        send_word(sphere_word(rand_coord(), rand_coord(), rand_coord(), rand_radius()));
        sent++;
      end
    end
    start <= 1'b0;

    // Drain outstanding results.
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire
